>>> sv/limit_order_book_matcher_top_assert.svh
// assertion macros for the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// implication checked at every clock edge outside reset
`define LOBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition that must never hold outside reset
`define LOBM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LOBM_ASSERT(lbl, prop, msg)
`define LOBM_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/lobm_pkg.sv
package lobm_pkg;

  localparam int OrderSlotsDefault = 32;

  localparam logic [1:0] ModeAdd    = 2'd0;
  localparam logic [1:0] ModeCancel = 2'd1;
  localparam logic [1:0] ModeModify = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatUnknown = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;

  localparam logic KindTrade  = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic SideBuy = 1'b0;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        order_ref;
    logic               buy_sell;
    logic signed [31:0] limit_price;
    logic [31:0]        order_qty;
  } event_t;

  typedef struct packed {
    logic               kind;
    logic               last;
    logic [31:0]        taker_ref;
    logic [31:0]        maker_id;
    logic signed [31:0] trade_price;
    logic [31:0]        trade_qty;
    logic [1:0]         status;
    logic [31:0]        rested_qty;
    logic signed [31:0] best_bid;
    logic               bid_present;
    logic signed [31:0] best_ask;
    logic               ask_present;
  } result_t;

  typedef struct packed {
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        ident;
    logic [31:0]        arrival;
  } slot_t;

endpackage

>>> sv/limit_order_book_matcher_top.sv
// Price-time priority limit order book. Orders rest in a slot memory with one read
// and one write port (registered read) beside per-slot valid flops; all searches
// are linear scans of that memory, one slot per cycle. A cancel or modify first
// scans for its id; an add or modify then runs one matching scan per trade, each
// followed by a trade step, and a last matching scan that finds no maker, skipped
// when the final trade used up the quantity or reached ORDER_SLOTS trades; a rest
// step stores the remainder, a final scan finds best bid/ask and a status step
// issues the status. The trade and status steps wait while the output register
// is full.
// Each event yields its trades then one status item with last set. One event is
// processed at a time; a result waiting in the output register does not hold up
// the next event's input.
`include "limit_order_book_matcher_top_assert.svh"

module limit_order_book_matcher_top
  import lobm_pkg::*;
#(
  parameter int ORDER_SLOTS = OrderSlotsDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    evt_valid,
  output logic    evt_ready,
  input  event_t  evt,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] NSLOT = CW'(ORDER_SLOTS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_MATCH = 7'b0000100,
    S_TRADE = 7'b0001000,
    S_REST  = 7'b0010000,
    S_BOOK  = 7'b0100000,
    S_STAT  = 7'b1000000
  } state_t;

  state_t state;

  // slot store
  slot_t mem [ORDER_SLOTS];
  slot_t rd_data;
  logic [IW-1:0] wr_addr;
  slot_t wr_data;
  logic  wr_en;
  logic [ORDER_SLOTS-1:0] valid;

  // event context
  event_t cur;
  logic               side;
  logic [31:0]        remaining;
  logic [CW-1:0]      ntrades;
  logic [31:0]        arrival_counter;
  logic [1:0]         stat;
  logic [31:0]        rested;

  // scan pipeline: address issue, then compare in the cycle after
  logic [CW-1:0] scan_cnt;
  logic          p_vld;
  logic [IW-1:0] p_idx;
  logic          scan_done;
  logic          scanning;

  // search results
  logic          found;
  logic [IW-1:0] best_idx;
  slot_t         best;
  logic signed [31:0] bid, ask;
  logic          bid_p, ask_p;

  logic          out_free;
  logic          emit;
  logic [31:0]   traded;
  logic [31:0]   arr_diff;
  logic          cand, better;
  logic          free_ok;
  logic [IW-1:0] free_idx;

  assign evt_ready = (state == S_IDLE);
  assign out_free  = !res_valid || res_ready;
  assign emit      = out_free && (state == S_TRADE || state == S_STAT);
  assign scanning  = (state == S_FIND) || (state == S_MATCH) || (state == S_BOOK);
  assign scan_done = (scan_cnt == NSLOT) && !p_vld;
  assign traded    = (remaining < best.qty) ? remaining : best.qty;

  // memory: one read, one write per cycle, writes only happen outside scans
  always_ff @(posedge clk) begin
    rd_data <= mem[scan_cnt[IW-1:0]];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // maker candidate and priority test on the entry just read
  always_comb begin
    arr_diff = best.arrival - rd_data.arrival;
    cand = p_vld && valid[p_idx] && (rd_data.side != side) &&
           ((side == SideBuy) ? (rd_data.price <= cur.limit_price)
                              : (rd_data.price >= cur.limit_price));
    if (!found) begin
      better = 1'b1;
    end else if (rd_data.price == best.price) begin
      better = (arr_diff != 32'd0) && !arr_diff[31];
    end else begin
      better = (side == SideBuy) ? (rd_data.price < best.price)
                                 : (rd_data.price > best.price);
    end
  end

  // lowest free slot
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_data = best;
    if (state == S_TRADE && out_free) begin
      wr_en       = 1'b1;
      wr_data.qty = best.qty - traded;
    end else if (state == S_REST && remaining != 32'd0 && free_ok) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = '{side: side, price: cur.limit_price, qty: remaining,
                  ident: cur.order_ref, arrival: arrival_counter};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      valid           <= '0;
      arrival_counter <= '0;
      res_valid       <= 1'b0;
      scan_cnt        <= '0;
      p_vld           <= 1'b0;
      found           <= 1'b0;
    end else begin
      // result register: load on a trade or status cycle, else drain
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      // scan address sequencing
      if (scanning && scan_cnt != NSLOT) begin
        scan_cnt <= scan_cnt + CW'(1);
        p_vld    <= 1'b1;
        p_idx    <= scan_cnt[IW-1:0];
      end else begin
        p_vld <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (evt_valid) begin
            cur       <= evt;
            side      <= evt.buy_sell;
            remaining <= evt.order_qty;
            ntrades   <= '0;
            stat      <= StatOk;
            rested    <= '0;
            scan_cnt  <= '0;
            found     <= 1'b0;
            bid_p     <= 1'b0;
            ask_p     <= 1'b0;
            if (evt.mode == ModeAdd) begin
              state <= S_MATCH;
            end else if (evt.mode == ModeCancel || evt.mode == ModeModify) begin
              state <= S_FIND;
            end else begin
              state <= S_BOOK;
            end
          end
        end
        S_FIND: begin
          if (p_vld && !found && valid[p_idx] && rd_data.ident == cur.order_ref) begin
            found    <= 1'b1;
            best_idx <= p_idx;
            best     <= rd_data;
          end
          if (scan_done) begin
            scan_cnt <= '0;
            found    <= 1'b0;
            if (!found) begin
              stat  <= StatUnknown;
              state <= S_BOOK;
            end else begin
              valid[best_idx] <= 1'b0;
              side            <= best.side;
              state           <= (cur.mode == ModeModify) ? S_MATCH : S_BOOK;
            end
          end
        end
        S_MATCH: begin
          if (cand && better) begin
            found    <= 1'b1;
            best_idx <= p_idx;
            best     <= rd_data;
          end
          if (scan_done) begin
            scan_cnt <= '0;
            state    <= (found && remaining != 32'd0) ? S_TRADE : S_REST;
          end
        end
        S_TRADE: begin
          if (out_free) begin
            res       <= '{kind: KindTrade, last: 1'b0, taker_ref: cur.order_ref,
                           maker_id: best.ident, trade_price: best.price,
                           trade_qty: traded, status: StatOk, rested_qty: '0,
                           best_bid: '0, bid_present: 1'b0, best_ask: '0,
                           ask_present: 1'b0};
            if (best.qty == traded) begin
              valid[best_idx] <= 1'b0;
            end
            remaining <= remaining - traded;
            ntrades   <= ntrades + CW'(1);
            found     <= 1'b0;
            scan_cnt  <= '0;
            state <= (remaining != traded && ntrades + CW'(1) != NSLOT) ? S_MATCH : S_REST;
          end
        end
        S_REST: begin
          if (remaining != 32'd0) begin
            if (free_ok) begin
              valid[free_idx] <= 1'b1;
              arrival_counter <= arrival_counter + 32'd1;
              rested          <= remaining;
            end else begin
              stat <= StatFull;
            end
          end
          scan_cnt <= '0;
          state    <= S_BOOK;
        end
        S_BOOK: begin
          if (p_vld && valid[p_idx]) begin
            if (rd_data.side == SideBuy) begin
              if (!bid_p || rd_data.price > bid) bid <= rd_data.price;
              bid_p <= 1'b1;
            end else begin
              if (!ask_p || rd_data.price < ask) ask <= rd_data.price;
              ask_p <= 1'b1;
            end
          end
          if (scan_done) begin
            state <= S_STAT;
          end
        end
        S_STAT: begin
          if (out_free) begin
            res       <= '{kind: KindStatus, last: 1'b1, taker_ref: '0, maker_id: '0,
                           trade_price: '0, trade_qty: '0, status: stat,
                           rested_qty: rested,
                           best_bid: bid_p ? bid : 32'sd0, bid_present: bid_p,
                           best_ask: ask_p ? ask : 32'sd0, ask_present: ask_p};
            scan_cnt  <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LOBM_ASSERT(a_start, evt_valid && evt_ready |=> scanning, "event did not start a scan")
  `LOBM_NEVER(a_wr_in_scan, wr_en && scanning, "slot write during a scan")
  `LOBM_NEVER(a_ntrades, ntrades > NSLOT, "too many trades for one event")
  `LOBM_ASSERT(a_trade_ok, state == S_TRADE |-> found && remaining != 32'd0, "bad trade")

endmodule
